@@ rtl/sliding_median_detrend_defines.svh @@
// assertion macros for the sliding median detrend block
`ifndef SLIDING_MEDIAN_DETREND_DEFINES_SVH
`define SLIDING_MEDIAN_DETREND_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define SMD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define SMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/smd_pkg.sv @@
// shared constants and types of the sliding median detrend block
package smd_pkg;

  localparam int MAX_HALF_WINDOW = 32;
  localparam int CHAIN_DEPTH     = 2 * MAX_HALF_WINDOW;
  localparam int MAX_RESULTS     = MAX_HALF_WINDOW + 1;
  localparam int VALUE_W         = 16;
  localparam int HW_W            = 6;
  localparam int SLOT_W          = $clog2(CHAIN_DEPTH);
  localparam int COUNT_W         = $clog2(CHAIN_DEPTH + 1);
  localparam int LEN_W           = $clog2(MAX_HALF_WINDOW + 1);
  localparam int RES_W           = $clog2(MAX_RESULTS + 1);
  localparam int MID_LO          = CHAIN_DEPTH / 2 - 1;

  localparam logic [HW_W-1:0] HALF_RESET = HW_W'(9);

  // sort tags: padding below, real samples, padding above
  localparam logic [1:0] TAG_LOW  = 2'd0;
  localparam logic [1:0] TAG_REAL = 2'd1;
  localparam logic [1:0] TAG_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0]         tag;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
  } key_t;

  typedef struct packed {
    logic below_del;
    logic below_new;
    key_t key;
  } link_t;

  typedef struct packed {
    logic clear;
    logic update;
    key_t new_key;
    key_t del_key;
  } chain_ctrl_t;

  localparam key_t PAD_LOW  = '{tag: TAG_LOW,  value: '0, slot: '0};
  localparam key_t PAD_HIGH = '{tag: TAG_HIGH, value: '0, slot: '0};

endpackage

@@ rtl/sliding_median_detrend.sv @@
// top level of the sliding median detrend block
//
// input channel: sample and last_in move on a transfer (in_valid high, in_stall
// low); last_in closes a curve. output channel: detrended and last_out move on
// out_valid high with out_stall low; last_out marks the final result of a curve.
// cfg_valid/cfg_ready write half_window (0 acts as 1, above 32 as 32); the value
// is latched at the first sample of each curve.
// an item is accepted in ST_IDLE, then ST_UPD does the chain update (it needs
// the registered read of the oldest window sample); the next item waits for
// ST_IDLE. once the first 2L samples are in, each item yields the result for
// sample k-L, loaded into the output register by that update. priming and the
// last sample start a flush, each result one read of the sample memory and one
// output load, at most 33 results per item; a longer flush resumes on the next
// item, which is dropped. reset loads the chain with padding and clears all
// counters; the sample memory needs no clearing. while the receiver stalls the
// output register holds its result and the sequencer waits before the next load.
module sliding_median_detrend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smd_pkg::HW_W-1:0]        half_window,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [smd_pkg::VALUE_W-1:0]     sample,
  input  logic                            last_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [smd_pkg::VALUE_W-1:0]     detrended,
  output logic                            last_out
);

  `include "sliding_median_detrend_defines.svh"

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transfer in
  localparam logic [2:0] ST_UPD  = 3'd1;  // chain update, steady result
  localparam logic [2:0] ST_MED  = 3'd2;  // take the median of the new window
  localparam logic [2:0] ST_CHK  = 3'd3;  // flush decision, memory read
  localparam logic [2:0] ST_OUT  = 3'd4;  // flush result into output register

  logic [2:0]                      state;
  logic [smd_pkg::HW_W-1:0]        half_reg;
  logic [smd_pkg::LEN_W-1:0]       cur_l;
  logic [smd_pkg::LEN_W-1:0]       half_clamped;
  logic [smd_pkg::COUNT_W-1:0]     win;
  logic [smd_pkg::COUNT_W-1:0]     fill;
  logic [smd_pkg::COUNT_W-1:0]     pending;
  logic [smd_pkg::SLOT_W-1:0]      wr_slot;
  logic [smd_pkg::SLOT_W-1:0]      rd_slot;
  logic [smd_pkg::SLOT_W-1:0]      del_slot;
  logic [smd_pkg::RES_W-1:0]       res_count;
  logic [smd_pkg::LEN_W-1:0]       keep_count;
  logic                            final_flush;
  logic                            primed;
  logic                            draining;
  logic [smd_pkg::VALUE_W-1:0]     s_hold;
  logic                            last_hold;
  logic [smd_pkg::VALUE_W-1:0]     med;
  logic [smd_pkg::VALUE_W-1:0]     chain_median;
  logic [smd_pkg::VALUE_W-1:0]     rd_a;
  logic [smd_pkg::VALUE_W-1:0]     rd_b;
  logic [smd_pkg::VALUE_W:0]       diff;
  logic [smd_pkg::VALUE_W-1:0]     result;
  logic [smd_pkg::VALUE_W-1:0]     store [smd_pkg::CHAIN_DEPTH];

  smd_pkg::chain_ctrl_t            chain_ctrl;

  logic in_xfer;
  logic accept_new;
  logic accept_drain;
  logic out_free;
  logic out_load;
  logic full;
  logic upd_go;
  logic prime_now;
  logic more;
  logic stream_done;
  logic rd_a_en;
  logic rd_b_en;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign accept_new   = in_xfer && !draining;
  assign accept_drain = in_xfer && draining;
  assign out_free  = !out_valid || !out_stall;

  // half window limits: zero acts as one, large values saturate
  always_comb begin
    if (half_reg == '0) begin
      half_clamped = smd_pkg::LEN_W'(1);
    end else if ({1'b0, half_reg} > (smd_pkg::HW_W + 1)'(smd_pkg::MAX_HALF_WINDOW)) begin
      half_clamped = smd_pkg::LEN_W'(smd_pkg::MAX_HALF_WINDOW);
    end else begin
      half_clamped = smd_pkg::LEN_W'(half_reg);
    end
  end

  assign win       = smd_pkg::COUNT_W'({cur_l, 1'b0});
  assign full      = (fill == win);
  assign del_slot  = wr_slot - win[smd_pkg::SLOT_W-1:0];
  assign upd_go    = !primed || out_free;
  assign prime_now = !primed && ((fill + smd_pkg::COUNT_W'(1)) == win);
  assign more      = (pending > smd_pkg::COUNT_W'(keep_count)) &&
                     (res_count < smd_pkg::RES_W'(smd_pkg::MAX_RESULTS));
  assign stream_done = !more && final_flush && (pending == '0);

  // a result enters the output register: steady result or one flush result
  assign out_load = ((state == ST_UPD) && upd_go && primed) ||
                    ((state == ST_OUT) && out_free);

  // sample minus median, negative clamps to zero
  assign diff   = {1'b0, rd_a} - {1'b0, med};
  assign result = diff[smd_pkg::VALUE_W] ? '0 : diff[smd_pkg::VALUE_W-1:0];

  // window chain: new sample in, oldest sample or one padding key out
  always_comb begin
    chain_ctrl.clear   = (state == ST_CHK) && stream_done;
    chain_ctrl.update  = (state == ST_UPD) && upd_go;
    chain_ctrl.new_key = '{tag: smd_pkg::TAG_REAL, value: s_hold, slot: wr_slot};
    if (full) begin
      chain_ctrl.del_key = '{tag: smd_pkg::TAG_REAL, value: rd_b, slot: del_slot};
    end else if (fill[0]) begin
      chain_ctrl.del_key = smd_pkg::PAD_HIGH;
    end else begin
      chain_ctrl.del_key = smd_pkg::PAD_LOW;
    end
  end

  smd_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (chain_ctrl),
    .odd_count (fill[0]),
    .median    (chain_median)
  );

  // sample memory: port a reads the next result's sample, port b the oldest
  // window sample
  assign rd_a_en = accept_new || ((state == ST_CHK) && more);
  assign rd_b_en = accept_new;

  always_ff @(posedge clk) begin
    if (chain_ctrl.update) begin
      store[wr_slot] <= s_hold;
    end
    if (rd_a_en) begin
      rd_a <= store[rd_slot];
    end
    if (rd_b_en) begin
      rd_b <= store[del_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      half_reg    <= smd_pkg::HALF_RESET;
      cur_l       <= smd_pkg::LEN_W'(smd_pkg::HALF_RESET);
      fill        <= '0;
      pending     <= '0;
      wr_slot     <= '0;
      rd_slot     <= '0;
      res_count   <= '0;
      keep_count  <= '0;
      final_flush <= 1'b0;
      primed      <= 1'b0;
      draining    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_reg <= half_window;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept_drain) begin
            // leftover flush of the previous curve; the item is dropped
            res_count   <= '0;
            keep_count  <= '0;
            final_flush <= 1'b1;
            state       <= ST_CHK;
          end else if (accept_new) begin
            if (fill == '0) begin
              cur_l <= half_clamped;
            end
            s_hold    <= sample;
            last_hold <= last_in;
            med       <= chain_median;
            state     <= ST_UPD;
          end
        end

        ST_UPD: begin
          if (upd_go) begin
            wr_slot <= wr_slot + smd_pkg::SLOT_W'(1);
            if (!full) begin
              fill <= fill + smd_pkg::COUNT_W'(1);
            end
            if (primed) begin
              // steady result for the sample half a window back
              detrended <= result;
              last_out  <= 1'b0;
              rd_slot   <= rd_slot + smd_pkg::SLOT_W'(1);
              res_count <= smd_pkg::RES_W'(1);
            end else begin
              pending   <= pending + smd_pkg::COUNT_W'(1);
              res_count <= '0;
            end
            if (prime_now) begin
              primed <= 1'b1;
            end
            final_flush <= last_hold;
            keep_count  <= last_hold ? '0 : cur_l;
            state       <= (prime_now || last_hold) ? ST_MED : ST_IDLE;
          end
        end

        ST_MED: begin
          med   <= chain_median;
          state <= ST_CHK;
        end

        ST_CHK: begin
          if (more) begin
            state <= ST_OUT;
          end else begin
            if (final_flush) begin
              if (pending == '0) begin
                fill     <= '0;
                primed   <= 1'b0;
                draining <= 1'b0;
              end else begin
                draining <= 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end

        ST_OUT: begin
          if (out_free) begin
            detrended <= result;
            last_out  <= final_flush && (pending == smd_pkg::COUNT_W'(1));
            pending   <= pending - smd_pkg::COUNT_W'(1);
            rd_slot   <= rd_slot + smd_pkg::SLOT_W'(1);
            res_count <= res_count + smd_pkg::RES_W'(1);
            state     <= ST_CHK;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // results owed never exceed the sample memory
  `SMD_ASSERT_ALWAYS(a_pending_bound, pending <= smd_pkg::COUNT_W'(smd_pkg::CHAIN_DEPTH), "pending count above memory depth")
  // once primed the chain holds exactly one full window
  `SMD_ASSERT_ALWAYS(a_primed_full, !primed || (fill == win), "primed with a partial window")
  // an item taken during a leftover flush goes straight to the flush loop
  `SMD_ASSERT_NEXT(a_drain_flush, accept_drain, state == ST_CHK, "leftover flush not started")

endmodule

@@ rtl/smd_cell.sv @@
// one cell of the sorted window chain: replace one key, insert another
module smd_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  smd_pkg::chain_ctrl_t ctrl,
  input  smd_pkg::key_t        clear_key,
  input  smd_pkg::link_t       lower,
  input  smd_pkg::link_t       upper,
  output smd_pkg::link_t       link
);

  smd_pkg::key_t key;
  smd_pkg::key_t key_next;
  smd_pkg::key_t d_cur;
  smd_pkg::key_t d_prev;
  logic          below_del;
  logic          below_new;
  logic          d_cur_lt;
  logic          d_prev_lt;

  assign below_del = key < ctrl.del_key;
  assign below_new = key < ctrl.new_key;

  assign link.below_del = below_del;
  assign link.below_new = below_new;
  assign link.key       = key;

  // view of the chain with the deleted key taken out
  always_comb begin
    d_cur     = below_del ? key : upper.key;
    d_cur_lt  = below_del ? below_new : upper.below_new;
    d_prev    = lower.below_del ? lower.key : key;
    d_prev_lt = lower.below_del ? lower.below_new : below_new;
    if (d_cur_lt) begin
      key_next = d_cur;
    end else if (d_prev_lt) begin
      key_next = ctrl.new_key;
    end else begin
      key_next = d_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      key <= clear_key;
    end else if (ctrl.update) begin
      key <= key_next;
    end
  end

endmodule

@@ rtl/smd_chain.sv @@
// padded sorted chain of window samples with the median at its center
module smd_chain (
  input  logic                               clk,
  input  logic                               rst,
  input  smd_pkg::chain_ctrl_t               ctrl,
  input  logic                               odd_count,
  output logic [smd_pkg::VALUE_W-1:0]        median
);

  smd_pkg::link_t                 links [smd_pkg::CHAIN_DEPTH+2];
  logic [smd_pkg::VALUE_W-1:0]    mid_lo;
  logic [smd_pkg::VALUE_W-1:0]    mid_hi;
  logic [smd_pkg::VALUE_W:0]      mid_sum;

  // boundaries: minus infinity below, plus infinity above
  assign links[0] = '{below_del: 1'b1, below_new: 1'b1, key: smd_pkg::PAD_LOW};
  assign links[smd_pkg::CHAIN_DEPTH+1] =
    '{below_del: 1'b0, below_new: 1'b0, key: smd_pkg::PAD_HIGH};

  for (genvar i = 0; i < smd_pkg::CHAIN_DEPTH; i++) begin : g_cell
    smd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .clear_key ((i < smd_pkg::CHAIN_DEPTH / 2) ? smd_pkg::PAD_LOW : smd_pkg::PAD_HIGH),
      .lower     (links[i]),
      .upper     (links[i+2]),
      .link      (links[i+1])
    );
  end

  assign mid_lo  = links[smd_pkg::MID_LO+1].key.value;
  assign mid_hi  = links[smd_pkg::MID_LO+2].key.value;
  assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
  assign median  = odd_count ? mid_lo : mid_sum[smd_pkg::VALUE_W:1];

endmodule
